FILE: hw/rtl/jdc_pkg.sv
package jdc_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  // Arctangent table depth and index width.
  localparam int TAB_LEN = 24;
  localparam int TAB_IW  = 5;

  // CORDIC coordinate and angle widths (angle in 1/64 degree with 16 fraction bits).
  localparam int XW = 36;
  localparam int ZW = 33;

  // Iterative divider: dividend, divisor and quotient widths.
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 15;
  localparam int DIV_QB = 15;

  localparam logic signed [ZW-1:0] Q_DEG90  = 33'sd377487360;
  localparam logic signed [ZW-1:0] Q_DEG180 = 33'sd754974720;
  localparam logic signed [ZW-1:0] Q_DEG270 = 33'sd1132462080;
  localparam logic signed [ZW-1:0] Q_DEG360 = 33'sd1509949440;

  localparam int FULL_TURN = 23040;
  localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

  // A full turn is 45 * 512; this is ceil(2^16 / 45), exact below 2260.
  localparam logic [10:0] SECTOR_RECIP = 11'd1457;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_MOVE  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_STICK_RADIUS    = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_DEAD_RADIUS     = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_DPAD_MODE       = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_DIRECTION_COUNT = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_AUTO_CENTER     = 3'd4;

  localparam logic [14:0] RST_STICK_RADIUS    = 15'd1024;
  localparam logic [5:0]  RST_DIRECTION_COUNT = 6'd4;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } in_word_t;

  typedef struct packed {
    logic               accepted;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [14:0]        angle;
    logic signed [15:0] thumb_x;
    logic signed [15:0] thumb_y;
  } out_word_t;

  typedef struct packed {
    logic [14:0] stick_radius;
    logic [14:0] dead_radius;
    logic        dpad_mode;
    logic [5:0]  direction_count;
    logic        auto_center;
  } cfg_t;

  typedef struct packed {
    logic ld_in;
    logic sq_x;
    logic sq_y;
    logic sq_r;
    logic sq_d;
    logic reject_take;
    logic commit_dead;
    logic cor_vec_start;
    logic z_wrap;
    logic ang_plain;
    logic k_mul;
    logic k_take;
    logic a_mul;
    logic a_div_start;
    logic a_take;
    logic rot_prep;
    logic cor_rot_start;
    logic rot_take;
    logic pass_take;
    logic vel_div_start;
    logic commit_live;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic reject;
    logic dead;
    logic dpad;
    logic clamp;
    logic r_zero;
    logic cor_done;
    logic div_done;
    logic div_ovf;
  } dp_stat_t;

  function automatic logic signed [ZW-1:0] atan_at(input logic [TAB_IW-1:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = 33'sd188743680;
      5'd1:  v = 33'sd111421900;
      5'd2:  v = 33'sd58872272;
      5'd3:  v = 33'sd29884485;
      5'd4:  v = 33'sd15000234;
      5'd5:  v = 33'sd7507429;
      5'd6:  v = 33'sd3754631;
      5'd7:  v = 33'sd1877430;
      5'd8:  v = 33'sd938729;
      5'd9:  v = 33'sd469366;
      5'd10: v = 33'sd234683;
      5'd11: v = 33'sd117342;
      5'd12: v = 33'sd58671;
      5'd13: v = 33'sd29335;
      5'd14: v = 33'sd14668;
      5'd15: v = 33'sd7334;
      5'd16: v = 33'sd3667;
      5'd17: v = 33'sd1833;
      5'd18: v = 33'sd917;
      5'd19: v = 33'sd458;
      5'd20: v = 33'sd229;
      5'd21: v = 33'sd115;
      5'd22: v = 33'sd57;
      5'd23: v = 33'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/joystick_deadzone_dpad_conditioner_core.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall   in_data   (in_word_t)
// out_     output     out_valid / out_stall out_data  (out_word_t)
// cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One word is worked on at a time; a new input word is taken once the previous
// result sits in the output register, even while that result is still stalled.
// A rejected begin or a dead-zone touch skips the CORDIC and the dividers; a live
// touch inside the circle takes one CORDIC vectoring pass and a clamped one adds a
// rotation pass, d-pad mode adds the sector arithmetic, and a zero radius saves
// the velocity division. The CORDIC unit and the bit-serial dividers set the run
// time; a stalled result holds the next one in place.
// Reset is synchronous and active low; no clearing pass follows it.
module joystick_deadzone_dpad_conditioner_core import jdc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [31:0]       cfg_data
);

  cfg_t     cfg_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stick_radius    <= RST_STICK_RADIUS;
      cfg_r.dead_radius     <= '0;
      cfg_r.dpad_mode       <= 1'b0;
      cfg_r.direction_count <= RST_DIRECTION_COUNT;
      cfg_r.auto_center     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STICK_RADIUS:    cfg_r.stick_radius    <= cfg_data[14:0];
        CFG_DEAD_RADIUS:     cfg_r.dead_radius     <= cfg_data[14:0];
        CFG_DPAD_MODE:       cfg_r.dpad_mode       <= cfg_data[0];
        CFG_DIRECTION_COUNT: cfg_r.direction_count <= cfg_data[5:0];
        CFG_AUTO_CENTER:     cfg_r.auto_center     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  jdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  jdc_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_word (out_data)
  );

endmodule

FILE: hw/rtl/jdc_cordic.sv
module jdc_cordic import jdc_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 vec_mode,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output logic                 done
);

  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 vec_r;
  logic [TAB_IW-1:0]    cnt_r;
  logic                 run_r;
  logic                 done_r;

  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] at;
  logic                 dir;

  // Vectoring drives y toward zero, rotation drives z toward zero.
  always_comb begin
    xs  = x_r >>> cnt_r;
    ys  = y_r >>> cnt_r;
    at  = atan_at(cnt_r);
    dir = vec_r ? (y_r >= 0) : (z_r < 0);
    if (dir) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == TAB_IW'(STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x_in;
      y_r   <= y_in;
      z_r   <= z_in;
      vec_r <= vec_mode;
    end else if (run_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;
  assign done  = done_r;

endmodule

FILE: hw/rtl/jdc_div.sv
module jdc_div import jdc_pkg::*; #(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW,
  parameter int QB = DIV_QB
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo,
  output logic          ovf,
  output logic          done
);

  localparam int HW = NW - QB;
  localparam int CW = $clog2(QB + 1);

  logic [DW-1:0] rem_r, den_r;
  logic [QB-1:0] lo_r, quo_r;
  logic          ovf_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;

  logic [HW-1:0] hi;
  logic [DW:0]   trial;
  logic          fits;

  // Restoring division, one quotient bit per cycle. The upper part of the
  // dividend must lie below the divisor, otherwise the quotient overflows.
  always_comb begin
    hi    = num[NW-1:QB];
    trial = {rem_r, lo_r[QB-1]};
    fits  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(QB);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ovf_r <= (hi >= HW'(den));
      rem_r <= hi[DW-1:0];
      lo_r  <= num[QB-1:0];
      den_r <= den;
      quo_r <= '0;
    end else if (run_r) begin
      rem_r <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      lo_r  <= {lo_r[QB-2:0], 1'b0};
      quo_r <= {quo_r[QB-2:0], fits};
    end
  end

  assign quo  = quo_r;
  assign ovf  = ovf_r;
  assign done = done_r;

endmodule

FILE: hw/rtl/jdc_datapath.sv
module jdc_datapath import jdc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  in_word_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_word_t out_word
);

  function automatic logic signed [15:0] thumb_round(input logic signed [XW-1:0] v);
    logic [XW-1:0]  mag;
    logic [XW-1:0]  rnd;
    logic [XW-17:0] q;
    logic [15:0]    res;
    mag = v[XW-1] ? XW'(-v) : XW'(v);
    rnd = mag + XW'(32768);
    q   = rnd[XW-1:16];
    if (v[XW-1]) begin
      res = (q >= (XW-16)'(32768)) ? 16'h8000 : 16'(~q[15:0] + 16'd1);
    end else begin
      res = (q >= (XW-16)'(32767)) ? 16'h7fff : q[15:0];
    end
    return $signed(res);
  endfunction

  function automatic logic signed [15:0] vel_of(input logic [DIV_QB-1:0] q,
                                                input logic ovf, input logic neg);
    logic [DIV_QB-1:0] m;
    m = (ovf || (q > DIV_QB'(16384))) ? DIV_QB'(16384) : q;
    return neg ? $signed(16'(-{1'b0, m})) : $signed({1'b0, m});
  endfunction

  logic [1:0]           cmd_r;
  logic signed [15:0]   px_r, py_r;
  logic [31:0]          dsq_r;
  logic [29:0]          rr_r, drr_r;
  logic signed [ZW-1:0] z_r, zr_r;
  logic [14:0]          ang_r;
  logic [37:0]          prod_r;
  logic [5:0]           k_r;
  logic [20:0]          an_r;
  logic signed [XW-1:0] xi_r;
  logic                 flip_r;
  logic signed [XW-1:0] vx_r, vy_r;
  logic signed [15:0]   tx_r, ty_r;

  logic signed [15:0]   held_vel_x_r, held_vel_y_r, held_thumb_x_r, held_thumb_y_r;
  logic [14:0]          held_angle_r;
  logic                 acc_r;
  out_word_t            out_r;

  logic [5:0]           n_cl;
  logic signed [16:0]   sq_op;
  logic [33:0]          sq_full;
  logic [31:0]          sq_res;
  logic signed [XW-1:0] xv0, yv0;
  logic signed [XW-1:0] cor_x0, cor_y0, cor_x, cor_y;
  logic signed [ZW-1:0] cor_z0, cor_z;
  logic                 cor_start, cor_done;
  logic signed [ZW-1:0] zt;
  logic [44:0]          gprod;
  logic signed [XW-1:0] cx, cy;
  logic [XW-1:0]        absx, absy, nsx, nsy;
  logic [19:0]          kn;
  logic [21:0]          kprod;
  logic [DIV_NW-1:0]    div0_num;
  logic [DIV_DW-1:0]    div0_den;
  logic                 div0_start;
  logic [DIV_QB-1:0]    q0, q1;
  logic                 ovf0, ovf1, done0, done1;

  always_comb begin
    if (cfg.direction_count == 6'd0) begin
      n_cl = 6'd1;
    end else if (cfg.direction_count > 6'd32) begin
      n_cl = 6'd32;
    end else begin
      n_cl = cfg.direction_count;
    end
  end

  // One shared squarer walks through x, y, radius and dead radius.
  always_comb begin
    sq_op = 17'sd0;
    if (cmd.sq_x) begin
      sq_op = 17'(px_r);
    end else if (cmd.sq_y) begin
      sq_op = 17'(py_r);
    end else if (cmd.sq_r) begin
      sq_op = $signed({2'b00, cfg.stick_radius});
    end else if (cmd.sq_d) begin
      sq_op = $signed({2'b00, cfg.dead_radius});
    end
    sq_full = 34'(sq_op * sq_op);
    sq_res  = sq_full[31:0];
  end

  always_comb begin
    xv0 = $signed({{(XW-32){px_r[15]}}, px_r, 16'h0});
    yv0 = $signed({{(XW-32){py_r[15]}}, py_r, 16'h0});
    if (cmd.cor_vec_start) begin
      // A vector in the left half plane is mirrored and starts at 180 degrees.
      cor_x0 = px_r[15] ? -xv0 : xv0;
      cor_y0 = px_r[15] ? -yv0 : yv0;
      cor_z0 = px_r[15] ? Q_DEG180 : '0;
    end else begin
      cor_x0 = xi_r;
      cor_y0 = '0;
      cor_z0 = zr_r;
    end
    cor_start = cmd.cor_vec_start | cmd.cor_rot_start;
  end

  jdc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cor_start),
    .vec_mode (cmd.cor_vec_start),
    .x_in     (cor_x0),
    .y_in     (cor_y0),
    .z_in     (cor_z0),
    .x_out    (cor_x),
    .y_out    (cor_y),
    .z_out    (cor_z),
    .done     (cor_done)
  );

  always_comb begin
    zt    = z_r + ZW'(32768);
    gprod = 45'(cfg.stick_radius) * 45'(CORDIC_GAIN_Q30);
    cx    = flip_r ? -cor_x : cor_x;
    cy    = flip_r ? -cor_y : cor_y;
    absx  = vx_r[XW-1] ? XW'(-vx_r) : XW'(vx_r);
    absy  = vy_r[XW-1] ? XW'(-vy_r) : XW'(vy_r);
    nsx   = absx + XW'({cfg.stick_radius, 1'b0});
    nsy   = absy + XW'({cfg.stick_radius, 1'b0});
    // The sector index is the rounded numerator over a full turn. The low nine
    // bits drop out exactly, and the remaining division by 45 is a reciprocal
    // multiplication that stays exact for every numerator that can occur.
    kn    = 20'(prod_r[37:16]) + 20'(FULL_TURN / 2);
    kprod = 22'(kn[19:9]) * 22'(SECTOR_RECIP);
    div0_start = cmd.a_div_start | cmd.vel_div_start;
    if (cmd.a_div_start) begin
      div0_num = DIV_NW'(an_r);
      div0_den = DIV_DW'(n_cl);
    end else begin
      div0_num = nsx[DIV_NW+1:2];
      div0_den = cfg.stick_radius;
    end
  end

  jdc_div u_div0 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div0_start),
    .num   (div0_num),
    .den   (div0_den),
    .quo   (q0),
    .ovf   (ovf0),
    .done  (done0)
  );

  jdc_div u_div1 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.vel_div_start),
    .num   (nsy[DIV_NW+1:2]),
    .den   (cfg.stick_radius),
    .quo   (q1),
    .ovf   (ovf1),
    .done  (done1)
  );

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      cmd_r <= in_data.command;
      if (in_data.command == CMD_END && cfg.auto_center) begin
        px_r <= '0;
        py_r <= '0;
      end else begin
        px_r <= in_data.pos_x;
        py_r <= in_data.pos_y;
      end
    end
    if (cmd.sq_x) begin
      dsq_r <= sq_res;
    end
    if (cmd.sq_y) begin
      dsq_r <= dsq_r + sq_res;
    end
    if (cmd.sq_r) begin
      rr_r <= sq_res[29:0];
    end
    if (cmd.sq_d) begin
      drr_r <= sq_res[29:0];
    end
    if (cmd.z_wrap) begin
      if (cor_z < 0) begin
        z_r <= cor_z + Q_DEG360;
      end else if (cor_z >= Q_DEG360) begin
        z_r <= cor_z - Q_DEG360;
      end else begin
        z_r <= cor_z;
      end
    end
    if (cmd.ang_plain) begin
      // A plain angle that rounds up to a full turn reads as zero.
      ang_r <= (zt[30:16] >= 15'(FULL_TURN)) ? 15'd0 : zt[30:16];
    end
    if (cmd.k_mul) begin
      prod_r <= 38'(z_r[31:0]) * 38'(n_cl);
    end
    if (cmd.k_take) begin
      k_r <= kprod[21:16];
    end
    if (cmd.a_mul) begin
      an_r <= 21'(k_r) * 21'(FULL_TURN) + 21'(n_cl >> 1);
    end
    if (cmd.a_take) begin
      ang_r <= q0;
      z_r   <= ZW'({q0, 16'h0});
    end
    if (cmd.rot_prep) begin
      xi_r <= XW'(gprod[44:14]);
      if (z_r > Q_DEG90 && z_r < Q_DEG270) begin
        zr_r   <= z_r - Q_DEG180;
        flip_r <= 1'b1;
      end else if (z_r >= Q_DEG270) begin
        zr_r   <= z_r - Q_DEG360;
        flip_r <= 1'b0;
      end else begin
        zr_r   <= z_r;
        flip_r <= 1'b0;
      end
    end
    if (cmd.rot_take) begin
      vx_r <= cx;
      vy_r <= cy;
      tx_r <= thumb_round(cx);
      ty_r <= thumb_round(cy);
    end
    if (cmd.pass_take) begin
      vx_r <= xv0;
      vy_r <= yv0;
      tx_r <= px_r;
      ty_r <= py_r;
    end
    if (cmd.reject_take) begin
      acc_r <= 1'b0;
    end
    if (cmd.commit_dead || cmd.commit_live) begin
      acc_r <= 1'b1;
    end
    if (cmd.load_out) begin
      out_r.accepted <= acc_r;
      out_r.vel_x    <= held_vel_x_r;
      out_r.vel_y    <= held_vel_y_r;
      out_r.angle    <= held_angle_r;
      out_r.thumb_x  <= held_thumb_x_r;
      out_r.thumb_y  <= held_thumb_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vel_x_r   <= '0;
      held_vel_y_r   <= '0;
      held_angle_r   <= '0;
      held_thumb_x_r <= '0;
      held_thumb_y_r <= '0;
    end else if (cmd.commit_dead) begin
      held_vel_x_r   <= '0;
      held_vel_y_r   <= '0;
      held_angle_r   <= '0;
      held_thumb_x_r <= px_r;
      held_thumb_y_r <= py_r;
    end else if (cmd.commit_live) begin
      held_vel_x_r   <= stat.r_zero ? 16'sd0 : vel_of(q0, ovf0, vx_r[XW-1]);
      held_vel_y_r   <= stat.r_zero ? 16'sd0 : vel_of(q1, ovf1, vy_r[XW-1]);
      held_angle_r   <= ang_r;
      held_thumb_x_r <= tx_r;
      held_thumb_y_r <= ty_r;
    end
  end

  // Both dividers run in lockstep for the velocity, so either done flag serves.
  always_comb begin
    stat.reject   = (cmd_r == CMD_BEGIN) && !({2'b00, rr_r} > dsq_r);
    stat.dead     = (dsq_r <= {2'b00, drr_r});
    stat.dpad     = cfg.dpad_mode;
    stat.clamp    = cfg.dpad_mode || (dsq_r > {2'b00, rr_r});
    stat.r_zero   = (cfg.stick_radius == 15'd0);
    stat.cor_done = cor_done;
    stat.div_done = done0 | done1;
    stat.div_ovf  = ovf0;
  end

  assign out_word = out_r;

endmodule

FILE: hw/rtl/jdc_ctrl.sv
module jdc_ctrl import jdc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SQX    = 5'd1;
  localparam logic [4:0] S_SQY    = 5'd2;
  localparam logic [4:0] S_SQR    = 5'd3;
  localparam logic [4:0] S_SQD    = 5'd4;
  localparam logic [4:0] S_DEC    = 5'd5;
  localparam logic [4:0] S_VWAIT  = 5'd6;
  localparam logic [4:0] S_ANG    = 5'd7;
  localparam logic [4:0] S_KMUL   = 5'd8;
  localparam logic [4:0] S_KDIV   = 5'd9;
  localparam logic [4:0] S_AMUL   = 5'd11;
  localparam logic [4:0] S_ADIV   = 5'd12;
  localparam logic [4:0] S_AWAIT  = 5'd13;
  localparam logic [4:0] S_CLMP   = 5'd14;
  localparam logic [4:0] S_ROT    = 5'd15;
  localparam logic [4:0] S_RWAIT  = 5'd16;
  localparam logic [4:0] S_VEL    = 5'd17;
  localparam logic [4:0] S_VDWAIT = 5'd18;
  localparam logic [4:0] S_COMMIT = 5'd19;
  localparam logic [4:0] S_OUT    = 5'd20;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        cmd.sq_x  = 1'b1;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.sq_y  = 1'b1;
        state_nxt = S_SQR;
      end
      S_SQR: begin
        cmd.sq_r  = 1'b1;
        state_nxt = S_SQD;
      end
      S_SQD: begin
        cmd.sq_d  = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (stat.reject) begin
          cmd.reject_take = 1'b1;
          state_nxt       = S_OUT;
        end else if (stat.dead) begin
          cmd.commit_dead = 1'b1;
          state_nxt       = S_OUT;
        end else begin
          cmd.cor_vec_start = 1'b1;
          state_nxt         = S_VWAIT;
        end
      end
      S_VWAIT: begin
        if (stat.cor_done) begin
          cmd.z_wrap = 1'b1;
          state_nxt  = S_ANG;
        end
      end
      S_ANG: begin
        cmd.ang_plain = 1'b1;
        state_nxt     = stat.dpad ? S_KMUL : S_CLMP;
      end
      S_KMUL: begin
        cmd.k_mul = 1'b1;
        state_nxt = S_KDIV;
      end
      S_KDIV: begin
        cmd.k_take = 1'b1;
        state_nxt  = S_AMUL;
      end
      S_AMUL: begin
        cmd.a_mul = 1'b1;
        state_nxt = S_ADIV;
      end
      S_ADIV: begin
        cmd.a_div_start = 1'b1;
        state_nxt       = S_AWAIT;
      end
      S_AWAIT: begin
        if (stat.div_done) begin
          cmd.a_take = 1'b1;
          state_nxt  = S_CLMP;
        end
      end
      S_CLMP: begin
        if (stat.clamp) begin
          cmd.rot_prep = 1'b1;
          state_nxt    = S_ROT;
        end else begin
          cmd.pass_take = 1'b1;
          state_nxt     = S_VEL;
        end
      end
      S_ROT: begin
        cmd.cor_rot_start = 1'b1;
        state_nxt         = S_RWAIT;
      end
      S_RWAIT: begin
        if (stat.cor_done) begin
          cmd.rot_take = 1'b1;
          state_nxt    = S_VEL;
        end
      end
      S_VEL: begin
        if (stat.r_zero) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.vel_div_start = 1'b1;
          state_nxt         = S_VDWAIT;
        end
      end
      S_VDWAIT: begin
        if (stat.div_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit_live = 1'b1;
        state_nxt       = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result word loaded over one still waiting");

  a_cor_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    stat.cor_done |-> (state_r == S_VWAIT || state_r == S_RWAIT))
    else $error("CORDIC finished outside a wait state");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state_r == S_AWAIT || state_r == S_VDWAIT))
    else $error("divider finished outside a wait state");

  a_sector_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.div_done && state_r == S_AWAIT) |-> !stat.div_ovf)
    else $error("sector division overflowed");

endmodule

FILE: dv/tb_joystick_deadzone_dpad_conditioner_core.sv
`timescale 1ns / 100ps

import jdc_pkg::*;

class stick_scoreboard;
  // Live register copy and the last result the model predicts.
  int unsigned radius, dead, dpad, dir_n, recentre;
  longint h_vx, h_vy, h_ang, h_tx, h_ty;
  out_word_t pending_words[$];
  int errors;

  function new();
    radius = 1024; dead = 0; dpad = 0; dir_n = 4; recentre = 1;
    h_vx = 0; h_vy = 0; h_ang = 0; h_tx = 0; h_ty = 0;
    errors = 0;
  endfunction

  function void write_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
    case (idx)
      CFG_STICK_RADIUS:    radius = val[14:0];
      CFG_DEAD_RADIUS:     dead = val[14:0];
      CFG_DPAD_MODE:       dpad = val[0];
      CFG_DIRECTION_COUNT: dir_n = val[5:0];
      CFG_AUTO_CENTER:     recentre = val[0];
      default: ;
    endcase
  endfunction

  static function longint shr(longint v, int s);
    return v >>> s;
  endfunction

  static function longint rdiv(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  static function longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  static function longint deg_q(longint d);
    return d * 64 * 65536;
  endfunction

  static function longint atan_q(int i);
    return longint'(atan_at(i[TAB_IW-1:0]));
  endfunction

  static function longint heading(longint px, longint py);
    longint x, y, z, xs, ys;
    x = px * 65536; y = py * 65536; z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = deg_q(180);
    end
    for (int i = 0; i < 16; i++) begin
      xs = shr(x, i); ys = shr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_q(i);
      end else begin
        x -= ys; y += xs; z -= atan_q(i);
      end
    end
    if (z < 0) z += deg_q(360);
    if (z >= deg_q(360)) z -= deg_q(360);
    return z;
  endfunction

  static function void spin(longint z, longint r, output longint cx, output longint cy);
    bit flip;
    longint x, y, xs, ys;
    flip = 0;
    x = (r * 652032874) >>> 14; y = 0;
    if (z > deg_q(90) && z < deg_q(270)) begin
      z -= deg_q(180); flip = 1;
    end else if (z >= deg_q(270)) begin
      z -= deg_q(360);
    end
    for (int i = 0; i < 16; i++) begin
      xs = shr(x, i); ys = shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_q(i);
      end else begin
        x += ys; y -= xs; z += atan_q(i);
      end
    end
    cx = flip ? -x : x;
    cy = flip ? -y : y;
  endfunction

  function void note_touch(in_word_t w);
    longint px, py, r, dr, dsq, z, ang, vx, vy, n, k;
    out_word_t e;
    bit ok;
    px = w.pos_x; py = w.pos_y; r = radius; dr = dead; ok = 1;
    if (w.command == CMD_END && recentre) begin
      px = 0; py = 0;
    end
    dsq = px * px + py * py;
    if (w.command == CMD_BEGIN && !(r * r > dsq)) begin
      ok = 0;
    end else if (dsq <= dr * dr) begin
      h_vx = 0; h_vy = 0; h_ang = 0; h_tx = px; h_ty = py;
    end else begin
      z = heading(px, py);
      if (dpad) begin
        n = clip(dir_n, 1, 32);
        k = rdiv(z * n, longint'(FULL_TURN) * 65536);
        ang = rdiv(k * FULL_TURN, n);
        z = ang * 65536;
      end else begin
        ang = (z + 32768) >>> 16;
        if (ang >= FULL_TURN) ang = 0;
      end
      if (dpad || dsq > r * r) begin
        spin(z, r, vx, vy);
        h_tx = clip(rdiv(vx, 65536), -32768, 32767);
        h_ty = clip(rdiv(vy, 65536), -32768, 32767);
      end else begin
        vx = px * 65536; vy = py * 65536; h_tx = px; h_ty = py;
      end
      if (r == 0) begin
        h_vx = 0; h_vy = 0;
      end else begin
        h_vx = clip(rdiv(vx * 16384, r * 65536), -16384, 16384);
        h_vy = clip(rdiv(vy * 16384, r * 65536), -16384, 16384);
      end
      h_ang = ang;
    end
    e.accepted = ok;
    e.vel_x = h_vx[15:0]; e.vel_y = h_vy[15:0]; e.angle = h_ang[14:0];
    e.thumb_x = h_tx[15:0]; e.thumb_y = h_ty[15:0];
    pending_words.push_back(e);
  endfunction

  function void check_word(out_word_t g);
    out_word_t e;
    if (pending_words.size() == 0) begin
      $error("unexpected result word %h", g);
      errors++;
      return;
    end
    e = pending_words.pop_front();
    if (g.accepted !== e.accepted) begin
      $error("accepted: expected %0d actual %0d", e.accepted, g.accepted); errors++;
    end
    if (g.vel_x !== e.vel_x) begin
      $error("vel_x: expected %0d actual %0d", e.vel_x, g.vel_x); errors++;
    end
    if (g.vel_y !== e.vel_y) begin
      $error("vel_y: expected %0d actual %0d", e.vel_y, g.vel_y); errors++;
    end
    if (g.angle !== e.angle) begin
      $error("angle: expected %0d actual %0d", e.angle, g.angle); errors++;
    end
    if (g.thumb_x !== e.thumb_x) begin
      $error("thumb_x: expected %0d actual %0d", e.thumb_x, g.thumb_x); errors++;
    end
    if (g.thumb_y !== e.thumb_y) begin
      $error("thumb_y: expected %0d actual %0d", e.thumb_y, g.thumb_y); errors++;
    end
  endfunction
endclass

module tb_joystick_deadzone_dpad_conditioner_core;
  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_word_t in_data;
  out_word_t out_data;
  logic [CFG_IW-1:0] cfg_index;
  logic [31:0] cfg_data;

  stick_scoreboard sb;
  int idle_pct;
  int quiet_cycles;
  int touches_sent;
  int settings_used;

  joystick_deadzone_dpad_conditioner_core u_dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Result side: random stall, check on every accepted word.
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_word(out_data);
      @(negedge clk);
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // Watchdog: any long run without a handshake ends the test.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles > 20000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Valid stays up after a handshake; a drain or the idle cycles of the next call lower it.
  task automatic send_touch(logic [1:0] cmd, logic [15:0] x, logic [15:0] y);
    in_word_t w;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    w.command = cmd; w.pos_x = x; w.pos_y = y;
    in_valid <= 1; in_data <= w;
    do @(posedge clk); while (in_stall);
    sb.note_touch(w);
    touches_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_words.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_setting(int r, int d, int dp, int n, int ac);
    drain();
    write_reg(CFG_STICK_RADIUS, r);
    write_reg(CFG_DEAD_RADIUS, d);
    write_reg(CFG_DPAD_MODE, dp);
    write_reg(CFG_DIRECTION_COUNT, n);
    write_reg(CFG_AUTO_CENTER, ac);
    cfg_valid <= 0;
    settings_used++;
  endtask

  // Positions mostly near the circle so that every region is reached.
  function automatic logic [15:0] coord(int r);
    int span;
    span = r * 3 / 2 + 8;
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(2 * span)) - span);
  endfunction

  task automatic random_phase(int count, int r);
    logic [1:0] cmd;
    for (int i = 0; i < count; i++) begin
      if (i % 8 == 0) cmd = CMD_BEGIN;
      else if (i % 8 == 7) cmd = CMD_END;
      else cmd = CMD_MOVE;
      if ($urandom_range(9) == 0) cmd = 2'($urandom);
      send_touch(cmd, coord(r), coord(r));
    end
  endtask

  initial begin
    sb = new();
    idle_pct = 12; touches_sent = 0; settings_used = 0;
    rst_n = 0; in_valid = 0; in_data = '0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: extremes, every command, rejects and recentring.
    send_touch(CMD_BEGIN, 16'h0000, 16'h0000);
    send_touch(CMD_BEGIN, 16'h7FFF, 16'h7FFF);
    send_touch(CMD_BEGIN, 16'h8000, 16'h8000);
    send_touch(CMD_BEGIN, 16'd1024, 16'd0);
    send_touch(CMD_BEGIN, 16'd1023, 16'd0);
    send_touch(CMD_MOVE, 16'h8000, 16'h7FFF);
    send_touch(CMD_MOVE, -16'sd500, 16'd0);
    send_touch(CMD_MOVE, 16'd300, -16'sd1);
    send_touch(2'd3, 16'd100, 16'd100);
    send_touch(CMD_END, 16'd700, 16'd700);
    send_touch(CMD_MOVE, 16'd1000, -16'sd2);
    apply_setting(1024, 200, 1, 8, 0);
    send_touch(CMD_END, 16'd700, 16'd700);
    send_touch(CMD_MOVE, 16'd50, 16'd50);
    send_touch(CMD_MOVE, 16'd1000, -16'sd10);
    apply_setting(0, 0, 0, 0, 1);
    send_touch(CMD_MOVE, 16'd5, 16'd5);
    send_touch(CMD_BEGIN, 16'd5, 16'd5);
    apply_setting(32767, 32767, 1, 63, 0);
    send_touch(CMD_MOVE, 16'h8000, 16'h8000);
    send_touch(CMD_MOVE, 16'h7FFF, 16'h0000);
    apply_setting(16, 0, 1, 1, 1);
    send_touch(CMD_MOVE, 16'd200, -16'sd300);
    send_touch(CMD_MOVE, 16'd0, 16'd1);

    for (int p = 0; p < 16; p++) begin
      int r;
      case (p % 4)
        0: r = 16;
        1: r = 32767;
        default: r = $urandom_range(16, 4000);
      endcase
      apply_setting(r, $urandom_range(r / 2), $urandom_range(1),
                    $urandom_range(63), $urandom_range(1));
      idle_pct = (p == 5) ? 0 : 12;
      random_phase(120, r);
      if (p == 9) drain();
    end

    drain();
    $display("covered %0d touch words across %0d register settings", touches_sent,
             settings_used);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/jdc_pkg.sv
hw/rtl/jdc_cordic.sv
hw/rtl/jdc_div.sv
hw/rtl/jdc_datapath.sv
hw/rtl/jdc_ctrl.sv
hw/rtl/joystick_deadzone_dpad_conditioner_core.sv
dv/tb_joystick_deadzone_dpad_conditioner_core.sv
